### src/sparse_row_l1_norm_unit_defines.svh
// Assertion macros for the sparse row l1 norm unit
`ifndef SPARSE_ROW_L1_NORM_UNIT_DEFINES_SVH
`define SPARSE_ROW_L1_NORM_UNIT_DEFINES_SVH

// same-cycle implication
`define SRL1N_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// next-cycle implication
`define SRL1N_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

### src/srl1n_pkg.sv
// Shared constants, codes and types of the sparse row l1 norm unit
package srl1n_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int ACC_BITS_DEF   = 48;
   localparam int OUT_BITS       = 48;
   localparam int FRAC_BITS      = 16;
   localparam int MARKER_BITS    = 4;
   localparam int QUEUE_DEPTH    = 4;
   localparam int MODE_BITS      = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 3;

   localparam logic [MODE_BITS-1:0] MODE_ABS_SUM  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_DIAG_OFF = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_SQUARES  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_WEIGHTED = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORM_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_MARKERS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFPART_EN  = 2'd2;

   typedef enum logic [1:0] {
      ADD_NONE,
      ADD_MAG,
      ADD_HALF,
      ADD_SQUARE
   } srl1n_add_type;

   typedef struct packed {
      logic first;
      logic last;
      logic neg;
      logic weighted;
   } srl1n_ctl_type;

   localparam int CTL_BITS = $bits(srl1n_ctl_type);

endpackage

### src/srl1n_front.sv
// Front end: configuration registers, entry classification and squaring pipeline
`include "sparse_row_l1_norm_unit_defines.svh"

module srl1n_front
   import srl1n_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int ACC_BITS   = ACC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [VALUE_BITS-1:0]     in_value,
   input  logic                      in_offpart,
   input  logic [MARKER_BITS-1:0]    in_row_marker,
   input  logic [MARKER_BITS-1:0]    in_col_marker,
   input  logic                      in_last,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [ACC_BITS-1:0]       out_addend,
   output logic [VALUE_BITS-1:0]     out_mag,
   output srl1n_ctl_type             out_ctl
);

   localparam int LO_BITS = VALUE_BITS / 2;
   localparam int HI_BITS = VALUE_BITS - LO_BITS;
   localparam int SQ_BITS = 2 * VALUE_BITS;
   localparam int WIDE    = (SQ_BITS > ACC_BITS) ? SQ_BITS : ACC_BITS;
   localparam logic [ACC_BITS-1:0] CAP = {1'b0, {(ACC_BITS-1){1'b1}}};

   logic [MODE_BITS-1:0] mode_ff;
   logic                 markers_ff;
   logic                 offpart_ff;
   logic                 row_start_ff;

   logic                 s1_valid_ff;
   logic [VALUE_BITS-1:0] s1_mag_ff;
   srl1n_ctl_type        s1_ctl_ff;
   srl1n_add_type        s1_sel_ff;

   logic                 s2_valid_ff;
   logic [VALUE_BITS-1:0] s2_mag_ff;
   srl1n_ctl_type        s2_ctl_ff;
   srl1n_add_type        s2_sel_ff;
   logic [2*HI_BITS-1:0] s2_phh_ff;
   logic [VALUE_BITS-1:0] s2_phl_ff;
   logic [2*LO_BITS-1:0] s2_pll_ff;

   logic                  s1_en;
   logic                  s2_en;
   logic                  take;
   logic                  neg_in;
   logic [VALUE_BITS-1:0] mag_in;
   logic                  off;
   logic                  filt_ok;
   logic                  part_ok;
   srl1n_add_type         sel_in;
   srl1n_ctl_type         ctl_in;
   logic [HI_BITS-1:0]    hi;
   logic [LO_BITS-1:0]    lo;
   logic [SQ_BITS-1:0]    sq_full;
   logic [WIDE-1:0]       raw;

   assign s2_en    = !s2_valid_ff || out_ready;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;
   assign take     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ABS_SUM;
         markers_ff <= 1'b0;
         offpart_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NORM_MODE:   mode_ff    <= csr_wdata;
            CSR_USE_MARKERS: markers_ff <= csr_wdata[0];
            CSR_OFFPART_EN:  offpart_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // classify the incoming word
   always_comb begin
      neg_in  = in_value[VALUE_BITS-1];
      mag_in  = neg_in ? (~in_value + VALUE_BITS'(1)) : in_value;
      off     = !row_start_ff && in_offpart;
      filt_ok = !markers_ff || (in_row_marker == in_col_marker);
      part_ok = !off || offpart_ff;
      unique case (mode_ff)
         MODE_ABS_SUM:
            sel_in = (part_ok && filt_ok) ? ADD_MAG : ADD_NONE;
         MODE_DIAG_OFF, MODE_WEIGHTED: begin
            if (row_start_ff)
               sel_in = ADD_MAG;
            else if (off && part_ok && filt_ok)
               sel_in = (mode_ff == MODE_WEIGHTED) ? ADD_HALF : ADD_MAG;
            else
               sel_in = ADD_NONE;
         end
         MODE_SQUARES:
            sel_in = part_ok ? ADD_SQUARE : ADD_NONE;
         default:
            sel_in = ADD_NONE;
      endcase
      ctl_in.first    = row_start_ff;
      ctl_in.last     = in_last;
      ctl_in.neg      = neg_in;
      ctl_in.weighted = (mode_ff == MODE_WEIGHTED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_start_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         if (take)
            row_start_ff <= in_last;
         if (s1_en)
            s1_valid_ff <= in_valid;
         if (s2_en)
            s2_valid_ff <= s1_valid_ff;
      end
   end

   assign hi = s1_mag_ff[VALUE_BITS-1:LO_BITS];
   assign lo = s1_mag_ff[LO_BITS-1:0];

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_mag_ff <= mag_in;
         s1_ctl_ff <= ctl_in;
         s1_sel_ff <= sel_in;
      end
      if (s2_en) begin
         s2_mag_ff <= s1_mag_ff;
         s2_ctl_ff <= s1_ctl_ff;
         s2_sel_ff <= s1_sel_ff;
         s2_phh_ff <= hi * hi;
         s2_phl_ff <= hi * lo;
         s2_pll_ff <= lo * lo;
      end
   end

   // combine partial products, pick and saturate the addend
   always_comb begin
      sq_full = (SQ_BITS'(s2_phh_ff) << (2 * LO_BITS))
              + (SQ_BITS'(s2_phl_ff) << (LO_BITS + 1))
              + SQ_BITS'(s2_pll_ff);
      unique case (s2_sel_ff)
         ADD_NONE:   raw = '0;
         ADD_MAG:    raw = WIDE'(s2_mag_ff);
         ADD_HALF:   raw = WIDE'(s2_mag_ff >> 1);
         ADD_SQUARE: raw = WIDE'(sq_full >> FRAC_BITS);
         default:    raw = '0;
      endcase
      out_addend = (raw > WIDE'(CAP)) ? CAP : ACC_BITS'(raw);
   end

   assign out_valid = s2_valid_ff;
   assign out_mag   = s2_mag_ff;
   assign out_ctl   = s2_ctl_ff;

   `SRL1N_ASSERT_IMPL(a_addend_capped, clock, reset, out_valid, out_addend <= CAP)

endmodule

### src/srl1n_queue.sv
// Short word queue between the front end and the accumulator
`include "sparse_row_l1_norm_unit_defines.svh"

module srl1n_queue
   import srl1n_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = data_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         data_ff[wr_ptr_ff] <= push_data;
   end

   `SRL1N_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH))
   `SRL1N_ASSERT_NEXT(a_pop_drops, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

### src/srl1n_back.sv
// Back end: saturating row accumulator, weighted-norm test and result register
`include "sparse_row_l1_norm_unit_defines.svh"

module srl1n_back
   import srl1n_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int ACC_BITS   = ACC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ACC_BITS-1:0]   in_addend,
   input  logic [VALUE_BITS-1:0] in_mag,
   input  srl1n_ctl_type         in_ctl,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [OUT_BITS-1:0]   out_norm,
   output logic                  out_zero
);

   localparam int BIG = (ACC_BITS > VALUE_BITS) ? ACC_BITS : VALUE_BITS;
   localparam int TB  = (BIG + 3 > OUT_BITS) ? BIG + 3 : OUT_BITS;
   localparam logic [ACC_BITS-1:0] CAP  = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] OMAX = {1'b0, {(OUT_BITS-1){1'b1}}};

   logic [ACC_BITS-1:0]   acc_ff;
   logic [VALUE_BITS-1:0] diag_ff;
   logic                  dneg_ff;

   logic                  fin_valid_ff;
   logic [ACC_BITS-1:0]   fin_sum_ff;
   logic [VALUE_BITS-1:0] fin_diag_ff;
   logic                  fin_neg_ff;
   logic                  fin_weighted_ff;

   logic                  out_valid_ff;
   logic [OUT_BITS-1:0]   out_norm_ff;
   logic                  out_zero_ff;

   logic                  rsp_free;
   logic                  fin_en;
   logic                  take;
   logic [ACC_BITS-1:0]   base;
   logic [ACC_BITS:0]     sum;
   logic [ACC_BITS-1:0]   sat_in;
   logic [VALUE_BITS-1:0] diag_cur;
   logic                  neg_cur;
   logic [TB-1:0]         three_n;
   logic [TB-1:0]         four_d;
   logic [TB-1:0]         d_cap;
   logic [TB-1:0]         pick;
   logic [OUT_BITS-1:0]   mag_out;
   logic [OUT_BITS-1:0]   norm_in;

   assign rsp_free = !out_valid_ff || out_ready;
   assign fin_en   = !fin_valid_ff || rsp_free;
   assign in_ready = fin_en;
   assign take     = in_valid && in_ready;

   // accumulate with saturation, restart on the diagonal
   always_comb begin
      base     = in_ctl.first ? '0 : acc_ff;
      sum      = {1'b0, base} + {1'b0, in_addend};
      sat_in   = (sum > {1'b0, CAP}) ? CAP : sum[ACC_BITS-1:0];
      diag_cur = in_ctl.first ? in_mag : diag_ff;
      neg_cur  = in_ctl.first ? in_ctl.neg : dneg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take)
            acc_ff <= in_ctl.last ? '0 : sat_in;
         if (fin_en)
            fin_valid_ff <= take && in_ctl.last;
         if (rsp_free)
            out_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_ctl.first) begin
         diag_ff <= in_mag;
         dneg_ff <= in_ctl.neg;
      end
      if (take && in_ctl.last) begin
         fin_sum_ff      <= sat_in;
         fin_diag_ff     <= diag_cur;
         fin_neg_ff      <= neg_cur;
         fin_weighted_ff <= in_ctl.weighted;
      end
   end

   // 3n <= 4d is the exact form of n <= floor(4d/3)
   always_comb begin
      three_n = TB'(fin_sum_ff) + (TB'(fin_sum_ff) << 1);
      four_d  = TB'(fin_diag_ff) << 2;
      d_cap   = (TB'(fin_diag_ff) < TB'(CAP)) ? TB'(fin_diag_ff) : TB'(CAP);
      pick    = (fin_weighted_ff && (three_n <= four_d)) ? d_cap : TB'(fin_sum_ff);
      mag_out = (pick > TB'(OMAX)) ? OMAX : OUT_BITS'(pick);
      norm_in = fin_neg_ff ? (~mag_out + OUT_BITS'(1)) : mag_out;
   end

   always_ff @(posedge clock) begin
      if (rsp_free && fin_valid_ff) begin
         out_norm_ff <= norm_in;
         out_zero_ff <= (mag_out == '0);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_norm  = out_norm_ff;
   assign out_zero  = out_zero_ff;

   `SRL1N_ASSERT_IMPL(a_acc_capped, clock, reset, 1'b1, acc_ff <= CAP)
   `SRL1N_ASSERT_NEXT(a_fin_holds, clock, reset, fin_valid_ff && !rsp_free, fin_valid_ff)
   `SRL1N_ASSERT_IMPL(a_zero_flag, clock, reset, out_valid_ff, out_zero_ff == (out_norm_ff == '0))

endmodule

### src/sparse_row_l1_norm_unit.sv
// Top level of the sparse row l1 norm unit
//
//  channel | dir | handshake         | contents
//  req     | in  | tvalid/tready     | one matrix nonzero, tlast ends the row
//  rsp     | out | tvalid/tready     | one signed row norm per row
//  csr     | in  | wr_en, no ready   | norm_mode, use_markers, offpart_enabled
//
// Throughput is one word per cycle while the rsp side does not stall; the accumulator adds one entry per cycle.
// A row norm leaves after the row's last word has passed, in order, the
// two front stages (classify, partial squares), the queue, accumulate and finish.
// Reset is synchronous: control and configuration registers return to their defaults, the next word opens a row.
// A stalled rsp side fills the result and finish registers, then the four-word
// queue, then the front stages, and only then drops req_tready.
module sparse_row_l1_norm_unit
   import srl1n_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int ACC_BITS   = ACC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // entry_value, row_marker, column_marker, zero fill
   input  logic [((VALUE_BITS+2*MARKER_BITS+7)/8)*8-1:0] req_tdata,
   // is_offpart
   input  logic                                           req_tuser,
   input  logic                                           req_tlast,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // row_norm
   output logic [OUT_BITS-1:0]                            rsp_tdata,
   // zero_norm
   output logic                                           rsp_tuser,
   input  logic                                           csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]                      csr_index,
   input  logic [CSR_DATA_BITS-1:0]                       csr_wdata
);

   localparam int Q_BITS = VALUE_BITS + ACC_BITS + CTL_BITS;

   logic                  f_valid;
   logic                  f_ready;
   logic [ACC_BITS-1:0]   f_addend;
   logic [VALUE_BITS-1:0] f_mag;
   srl1n_ctl_type         f_ctl;
   logic                  b_valid;
   logic                  b_ready;
   logic [Q_BITS-1:0]     b_data;
   srl1n_ctl_type         b_ctl;

   srl1n_front #(
      .VALUE_BITS(VALUE_BITS),
      .ACC_BITS(ACC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_value(req_tdata[VALUE_BITS-1:0]),
      .in_offpart(req_tuser),
      .in_row_marker(req_tdata[VALUE_BITS+MARKER_BITS-1:VALUE_BITS]),
      .in_col_marker(req_tdata[VALUE_BITS+2*MARKER_BITS-1:VALUE_BITS+MARKER_BITS]),
      .in_last(req_tlast),
      .out_valid(f_valid),
      .out_ready(f_ready),
      .out_addend(f_addend),
      .out_mag(f_mag),
      .out_ctl(f_ctl)
   );

   srl1n_queue #(
      .WIDTH(Q_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data({f_mag, f_addend, f_ctl}),
      .pop_valid(b_valid),
      .pop_ready(b_ready),
      .pop_data(b_data)
   );

   assign b_ctl = b_data[CTL_BITS-1:0];

   srl1n_back #(
      .VALUE_BITS(VALUE_BITS),
      .ACC_BITS(ACC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(b_valid),
      .in_ready(b_ready),
      .in_addend(b_data[CTL_BITS+ACC_BITS-1:CTL_BITS]),
      .in_mag(b_data[Q_BITS-1:CTL_BITS+ACC_BITS]),
      .in_ctl(b_ctl),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_norm(rsp_tdata),
      .out_zero(rsp_tuser)
   );

endmodule

### bench/sparse_row_l1_norm_unit_test.sv
// Self-checking testbench of the sparse row l1 norm unit with a built-in row norm predictor
`timescale 1ns / 100ps

module sparse_row_l1_norm_unit_test;
   import srl1n_pkg::*;

   localparam int REQ_BITS = ((VALUE_BITS_DEF + 2*MARKER_BITS + 7) / 8) * 8;
   localparam logic [63:0] ACC_CAP = (64'd1 << (ACC_BITS_DEF - 1)) - 64'd1;
   localparam logic [63:0] OUT_MAX = (64'd1 << (OUT_BITS - 1)) - 64'd1;
   localparam logic [MODE_BITS-1:0] MODE_UNDEF_LOW  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_UNDEF_HIGH = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;

   typedef struct packed {
      logic [VALUE_BITS_DEF-1:0] value;
      logic                      is_off;
      logic [MARKER_BITS-1:0]    row_marker;
      logic [MARKER_BITS-1:0]    col_marker;
      logic                      last;
   } nz_word_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] norm;
      logic                zero;
   } row_norm_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [OUT_BITS-1:0]       rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic [MODE_BITS-1:0] mode_q;
   logic                 markers_q;
   logic                 offpart_q;
   logic [63:0]          norm_acc_q;
   logic [63:0]          diag_mag_q;
   logic                 diag_neg_q;
   logic                 row_open_q;

   row_norm_type expected_norms[$];
   int        mismatches = 0;
   bit        idle_on = 1'b1;
   bit        hold_active = 1'b0;
   event      start_hold;

   sparse_row_l1_norm_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
      if (x > ACC_CAP || y > ACC_CAP - x)
         return ACC_CAP;
      return x + y;
   endfunction

   function automatic bit predict_norm(input nz_word_type w, output row_norm_type r);
      logic [31:0] neg_val;
      logic [63:0] mag, a, b, addend, n;
      logic        neg, row_first, is_off, filt_ok, part_ok;
      r = '0;
      neg = w.value[VALUE_BITS_DEF-1];
      neg_val = ~w.value + 32'd1;
      mag = neg ? {32'd0, neg_val} : {32'd0, w.value};
      row_first = row_open_q;
      is_off = !row_first && w.is_off;
      filt_ok = !markers_q || (w.row_marker == w.col_marker);
      part_ok = !is_off || offpart_q;
      if (row_first) begin
         diag_mag_q = mag;
         diag_neg_q = neg;
         norm_acc_q = 64'd0;
         row_open_q = 1'b0;
      end
      case (mode_q)
         MODE_ABS_SUM: begin
            if (part_ok && filt_ok)
               norm_acc_q = sat_add(norm_acc_q, mag);
         end
         MODE_DIAG_OFF, MODE_WEIGHTED: begin
            if (row_first)
               norm_acc_q = sat_add(norm_acc_q, mag);
            else if (is_off && part_ok && filt_ok)
               norm_acc_q = sat_add(norm_acc_q, (mode_q == MODE_WEIGHTED) ? (mag >> 1) : mag);
         end
         MODE_SQUARES: begin
            if (part_ok) begin
               a = mag >> FRAC_BITS;
               b = mag & 64'hFFFF;
               if (a >= (64'd1 << 24))
                  addend = ACC_CAP;
               else
                  addend = sat_add((a * a) << FRAC_BITS, 64'd2 * a * b + ((b * b) >> FRAC_BITS));
               norm_acc_q = sat_add(norm_acc_q, addend);
            end
         end
         default: ;
      endcase
      if (!w.last)
         return 1'b0;
      n = norm_acc_q;
      if (mode_q == MODE_WEIGHTED && n <= (64'd4 * diag_mag_q) / 64'd3)
         n = (diag_mag_q < ACC_CAP) ? diag_mag_q : ACC_CAP;
      if (n > OUT_MAX)
         n = OUT_MAX;
      r.norm = diag_neg_q ? (48'd0 - n[OUT_BITS-1:0]) : n[OUT_BITS-1:0];
      r.zero = (n == 64'd0);
      norm_acc_q = 64'd0;
      row_open_q = 1'b1;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch %s: want %h got %h at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   task automatic send_word(input logic [31:0] value, input logic is_off,
                            input logic [3:0] row_marker, input logic [3:0] col_marker,
                            input logic last);
      nz_word_type  w;
      row_norm_type r;
      w = '{value, is_off, row_marker, col_marker, last};
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w.col_marker, w.row_marker, w.value};
      req_tuser  <= w.is_off;
      req_tlast  <= w.last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (predict_norm(w, r))
         expected_norms.push_back(r);
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_norms.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_NORM_MODE:   mode_q = data;
         CSR_USE_MARKERS: markers_q = data[0];
         CSR_OFFPART_EN:  offpart_q = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [MODE_BITS-1:0] mode, input logic markers,
                            input logic offpart);
      logic [1:0] junk;
      settle_idle();
      junk = 2'($urandom_range(0, 3));
      write_csr(CSR_NORM_MODE, mode);
      write_csr(CSR_USE_MARKERS, {junk, markers});
      junk = 2'($urandom_range(0, 3));
      write_csr(CSR_OFFPART_EN, {junk, offpart});
   endtask

   task automatic send_random_rows(input int words, input int max_len);
      int          sent, len, n_local, i;
      bit          noisy;
      logic [3:0]  rm, wrm, wcm;
      logic [31:0] value;
      sent = 0;
      while (sent < words) begin
         len = $urandom_range(1, max_len);
         noisy = ($urandom_range(0, 9) == 0);
         rm = 4'($urandom);
         n_local = $urandom_range(0, len - 1);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
               0: value = 32'h0000_0000;
               1: value = 32'h8000_0000;
               2: value = 32'h7FFF_FFFF;
               3: value = 32'hFFFF_FFFF;
               4: value = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
               default: value = $urandom;
            endcase
            wrm = noisy ? 4'($urandom) : rm;
            wcm = $urandom_range(0, 1) ? wrm : 4'($urandom);
            send_word(value, noisy ? 1'($urandom) : (i > n_local), wrm, wcm, i == len - 1);
            sent++;
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_word(32'h8000_0000, 1'b0, 4'h0, 4'h0, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b1, 4'h0, 4'h0, 1'b1);
      send_word(32'h0000_0000, 1'b0, 4'h0, 4'h0, 1'b1);
   endtask

   task automatic test_directed_modes();
      configure(MODE_DIAG_OFF, 1'b0, 1'b1);
      send_word(32'hFFFB_0000, 1'b1, 4'h0, 4'h0, 1'b0);
      send_word(32'h0007_0000, 1'b0, 4'h0, 4'h0, 1'b0);
      send_word(32'h0009_0000, 1'b1, 4'h0, 4'h0, 1'b1);
      configure(MODE_SQUARES, 1'b1, 1'b1);
      send_word(32'h8000_0000, 1'b0, 4'h1, 4'h2, 1'b0);
      send_word(32'h8000_0000, 1'b1, 4'h1, 4'h3, 1'b1);
      send_word(32'h0001_8000, 1'b0, 4'h5, 4'h5, 1'b1);
      configure(MODE_WEIGHTED, 1'b0, 1'b1);
      send_word(32'h0003_0000, 1'b0, 4'h0, 4'h0, 1'b0);
      send_word(32'h0001_0000, 1'b1, 4'h0, 4'h0, 1'b1);
      send_word(32'hFFFF_0000, 1'b0, 4'h0, 4'h0, 1'b0);
      send_word(32'h0008_0000, 1'b1, 4'h0, 4'h0, 1'b1);
      configure(MODE_UNDEF_LOW, 1'b0, 1'b1);
      send_word(32'h0000_0005, 1'b0, 4'h0, 4'h0, 1'b0);
      send_word(32'h0000_0006, 1'b1, 4'h0, 4'h0, 1'b1);
      configure(MODE_UNDEF_HIGH, 1'b0, 1'b1);
      send_word(32'h0000_0001, 1'b0, 4'h0, 4'h0, 1'b1);
      configure(MODE_ABS_SUM, 1'b1, 1'b1);
      write_csr(CSR_UNUSED, 3'd7);
      send_word(32'h0002_0000, 1'b0, 4'h8, 4'h7, 1'b0);
      send_word(32'h0001_0000, 1'b1, 4'h8, 4'h8, 1'b1);
      configure(MODE_ABS_SUM, 1'b0, 1'b0);
      send_word(32'h0001_0000, 1'b0, 4'h0, 4'h0, 1'b0);
      send_word(32'h0002_0000, 1'b1, 4'h0, 4'h0, 1'b1);
   endtask

   task automatic test_random_rows();
      int ph;
      for (ph = 0; ph < 12; ph++) begin
         if (ph < 4)
            configure(MODE_BITS'(MODE_ABS_SUM + ph), 1'b0, 1'b1);
         else if (ph < 8)
            configure(MODE_BITS'(MODE_ABS_SUM + ph - 4), 1'b1, 1'b0);
         else
            configure(MODE_BITS'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         send_random_rows(100, 8);
      end
   endtask

   task automatic test_full_throughput();
      configure(MODE_WEIGHTED, 1'b0, 1'b1);
      idle_on = 1'b0;
      send_random_rows(60, 6);
      settle_idle();
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      configure(MODE_ABS_SUM, 1'b1, 1'b1);
      idle_on = 1'b0;
      -> start_hold;
      send_random_rows(80, 2);
      settle_idle();
      idle_on = 1'b1;
   endtask

   always @(negedge clock)
      rsp_tready <= hold_active ? 1'b0 : (!idle_on || $urandom_range(0, 99) >= 25);

   always begin
      @(start_hold);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   always @(posedge clock) begin : check_rows
      row_norm_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_norms.size() == 0) begin
            report_mismatch("unexpected row norm", 64'd0, {16'd0, rsp_tdata});
         end else begin
            want = expected_norms.pop_front();
            if (rsp_tdata !== want.norm)
               report_mismatch("row_norm", {16'd0, want.norm}, {16'd0, rsp_tdata});
            if (rsp_tuser !== want.zero)
               report_mismatch("zero_norm", {63'd0, want.zero}, {63'd0, rsp_tuser});
         end
      end
   end

   initial begin : watchdog
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall = 0;
         else
            stall++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      mode_q = MODE_ABS_SUM;
      markers_q = 1'b0;
      offpart_q = 1'b1;
      norm_acc_q = 64'd0;
      diag_mag_q = 64'd0;
      diag_neg_q = 1'b0;
      row_open_q = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_modes();
      test_random_rows();
      test_full_throughput();
      test_backpressure();
      settle_idle();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/srl1n_pkg.sv
src/srl1n_front.sv
src/srl1n_queue.sv
src/srl1n_back.sv
src/sparse_row_l1_norm_unit.sv
bench/sparse_row_l1_norm_unit_test.sv
